FILE: design/pid_likelihood_interpolator_defines.svh
// Assertion macros used by the checker of this block.
`ifndef PID_LIKELIHOOD_INTERPOLATOR_DEFINES_SVH
`define PID_LIKELIHOOD_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define PLI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define PLI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pli_pkg.sv
package pli_pkg;

    // Item kinds carried on s_tuser
    localparam logic [2:0] KIND_WR_ELOSS = 3'd0;
    localparam logic [2:0] KIND_WR_TIME  = 3'd1;
    localparam logic [2:0] KIND_WR_GRID  = 3'd2;
    localparam logic [2:0] KIND_Q_ELOSS  = 3'd3;
    localparam logic [2:0] KIND_Q_TIME   = 3'd4;

    // Configuration register indexes
    localparam logic CFG_CHARGE_SCALE = 1'b0;
    localparam logic CFG_BINS_IN_USE  = 1'b1;

    localparam int PROB_W = 24;
    localparam int IN_DATA_W = 72;

    localparam logic signed [PROB_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [PROB_W-1:0] OUT_MIN = 24'sh800000;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // How a query result is formed after the grid scan
    typedef enum logic [1:0] {
        MODE_CONST = 2'd0,
        MODE_READ  = 2'd1,
        MODE_LINE  = 2'd2
    } mode_t;

endpackage

FILE: design/pid_likelihood_interpolator.sv
// Likelihood lookup with piecewise-linear interpolation over a momentum grid.
// Input channel s_*: one item per transfer, s_tuser carries the kind. Table,
// time-table and grid writes complete in the transfer cycle and give no result.
// Energy-loss and time queries give one result each on m_*: m_tdata holds the
// signed Q7.16 probability, m_tuser flags a saturated value.
// Configuration: cfg_we writes charge_scale (index 0) or bins_in_use (index 1)
// from cfg_wdata at the clock edge; write only while the block is idle.
// A query passes from its transfer to m_tvalid through these steps: the grid is
// scanned one row per cycle through its single read port, two table rows are
// read from the table memory, one 17x17 multiply, then a 33-step bit-serial
// signed divider. Constant, single-row and zero-span results skip the divider.
// One query is worked on at a time; s_tready is high only between queries.
// A finished result sits in the output register; if m_tready is low the block
// holds it there and waits before finishing the next query.
// Reset (aresetn low, synchronous) returns to idle, drops any pending result
// and restores the configuration registers; table memories are not cleared
// and must be loaded before they are queried.
module pid_likelihood_interpolator #(
    parameter int GRID_POINTS = 11,
    parameter int ELOSS_BINS  = 128,
    parameter int TIME_BINS   = 32,
    parameter int SPECIES     = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [23:0] cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: species[2:0], grid_index[6:3], bin_index[13:7], table_value[29:14],
    //        momentum[45:30], charge[61:46], time_bin[66:62], zero pad[71:67]
    input  logic [pli_pkg::IN_DATA_W-1:0] s_tdata,
    // tuser: kind[2:0]
    input  logic [2:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: probability[23:0]
    output logic [pli_pkg::PROB_W-1:0] m_tdata,
    // tuser: saturated[0]
    output logic        m_tuser
);

    localparam int GW     = (GRID_POINTS > 2) ? $clog2(GRID_POINTS) : 1;
    localparam int CW     = $clog2(GRID_POINTS + 1);
    localparam int EBW    = $clog2(ELOSS_BINS);
    localparam int TBW    = $clog2(TIME_BINS);
    localparam int SPW    = $clog2(SPECIES);
    localparam int EL_DEPTH = GRID_POINTS * SPECIES * ELOSS_BINS;
    localparam int TM_DEPTH = GRID_POINTS * 2 * TIME_BINS;
    localparam int EL_AW  = $clog2(EL_DEPTH);
    localparam int TM_AW  = $clog2(TM_DEPTH);
    localparam int QW     = 33;
    localparam int DCW    = $clog2(QW + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_BIN    = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_DECIDE = 4'd3;
    localparam logic [3:0] ST_RDA    = 4'd4;
    localparam logic [3:0] ST_RDB    = 4'd5;
    localparam logic [3:0] ST_MUL    = 4'd6;
    localparam logic [3:0] ST_DIVI   = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_SUM    = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    // unpack the input transfer
    logic [2:0]  in_kind;
    logic [2:0]  in_species;
    logic [3:0]  in_grid;
    logic [6:0]  in_bin;
    logic [15:0] in_value;
    logic [15:0] in_momentum;
    logic [15:0] in_charge;
    logic [4:0]  in_tbin;

    assign in_kind     = s_tuser;
    assign in_species  = s_tdata[2:0];
    assign in_grid     = s_tdata[6:3];
    assign in_bin      = s_tdata[13:7];
    assign in_value    = s_tdata[29:14];
    assign in_momentum = s_tdata[45:30];
    assign in_charge   = s_tdata[61:46];
    assign in_tbin     = s_tdata[66:62];

    logic [3:0]  state_reg, state_next;
    logic [23:0] scale_reg;
    logic [7:0]  bins_reg;

    // latched query
    logic        is_time_reg;
    logic [2:0]  sp_reg;
    logic [15:0] m_reg;
    logic [15:0] charge_reg;
    logic [4:0]  tb_reg;

    logic [39:0]    binprod_reg;
    logic [EBW-1:0] bin_reg;

    // grid scan
    logic [CW-1:0]  scan_cnt_reg;
    logic [15:0]    g0_reg, g1_reg, gn2_reg, gn1_reg, gprev_reg;
    logic [15:0]    ia_reg, ib_reg;
    logic [GW-1:0]  ir_reg;
    logic           found_reg;

    // decision
    pli_pkg::mode_t mode_reg;
    logic [16:0]    const_reg;
    logic [GW-1:0]  ra_reg, rb_reg;
    logic [15:0]    ga_reg, gb_reg, bg_reg;
    logic           base_b_reg;

    // arithmetic
    logic [15:0]           va_reg;
    logic [15:0]           basev_reg;
    logic signed [33:0]    prod_reg;
    logic signed [16:0]    den_reg;
    logic [15:0]           dsor_reg;
    logic [15:0]           rem_reg;
    logic [QW-1:0]         quo_reg;
    logic                  neg_reg;
    logic [DCW-1:0]        div_cnt_reg;
    logic [16:0]           res_reg;
    logic signed [pli_pkg::PROB_W-1:0] prob_reg;
    logic                  sat_reg;

    logic                        m_tvalid_reg;
    logic [pli_pkg::PROB_W-1:0]  m_tdata_reg;
    logic                        m_tuser_reg;

    // memories
    logic [15:0] grid_mem [GRID_POINTS];
    logic [15:0] el_mem   [EL_DEPTH];
    logic [15:0] tm_mem   [TM_DEPTH];
    logic [15:0] grid_q_reg, el_q_reg, tm_q_reg;

    function automatic logic [EL_AW-1:0] el_addr(input logic [GW-1:0] row,
                                                 input logic [SPW-1:0] sp,
                                                 input logic [EBW-1:0] bin);
        el_addr = EL_AW'((int'(row) * SPECIES + int'(sp)) * ELOSS_BINS + int'(bin));
    endfunction

    function automatic logic [TM_AW-1:0] tm_addr(input logic [GW-1:0] row,
                                                 input logic tab,
                                                 input logic [TBW-1:0] bin);
        tm_addr = TM_AW'((int'(row) * 2 + int'(tab)) * TIME_BINS + int'(bin));
    endfunction

    logic s_xfer;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // write decode on the transfer cycle
    logic el_we, tm_we, grid_we;
    assign el_we   = s_xfer && (in_kind == pli_pkg::KIND_WR_ELOSS)
                     && (int'(in_grid) < GRID_POINTS) && (int'(in_species) < SPECIES)
                     && (int'(in_bin) < ELOSS_BINS);
    assign tm_we   = s_xfer && (in_kind == pli_pkg::KIND_WR_TIME)
                     && (int'(in_grid) < GRID_POINTS) && (in_species < 3'd2)
                     && (int'(in_bin) < TIME_BINS);
    assign grid_we = s_xfer && (in_kind == pli_pkg::KIND_WR_GRID)
                     && (int'(in_grid) < GRID_POINTS);

    // read addresses: row A in ST_RDA, row B otherwise
    logic [GW-1:0]  rd_row;
    logic           tab;
    logic [TBW-1:0] tb_idx;
    assign rd_row = (state_reg == ST_RDA) ? ra_reg : rb_reg;
    assign tab    = (sp_reg != 3'd0);
    assign tb_idx = TBW'(tb_reg);

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[in_grid[GW-1:0]] <= in_value;
        end
        grid_q_reg <= grid_mem[scan_cnt_reg[GW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (el_we) begin
            el_mem[el_addr(in_grid[GW-1:0], in_species[SPW-1:0], EBW'(in_bin))] <= in_value;
        end
        el_q_reg <= el_mem[el_addr(rd_row, sp_reg[SPW-1:0], bin_reg)];
    end

    always_ff @(posedge aclk) begin
        if (tm_we) begin
            tm_mem[tm_addr(in_grid[GW-1:0], in_species[0], TBW'(in_bin))] <= in_value;
        end
        tm_q_reg <= tm_mem[tm_addr(rd_row, tab, tb_idx)];
    end

    logic [15:0] mem_q;
    assign mem_q = is_time_reg ? tm_q_reg : el_q_reg;

    // energy-loss bin: scaled charge capped at the bins in use
    logic [EBW-1:0] cap_m1;
    logic [23:0]    bin_raw;
    logic [EBW-1:0] bin_capped;
    always_comb begin
        if (bins_reg == 8'd0) begin
            cap_m1 = '0;
        end else if (int'(bins_reg) > ELOSS_BINS) begin
            cap_m1 = EBW'(ELOSS_BINS - 1);
        end else begin
            cap_m1 = EBW'(bins_reg - 8'd1);
        end
        bin_raw = binprod_reg[39:16];
        if (int'(bin_raw) > int'(cap_m1)) begin
            bin_capped = cap_m1;
        end else begin
            bin_capped = EBW'(bin_raw);
        end
    end

    // scan: the grid word of row scan_cnt-1 is in grid_q_reg
    logic [CW-1:0] scan_j;
    assign scan_j = scan_cnt_reg - CW'(1);

    // pick the result form and the rows and grid points it needs
    pli_pkg::mode_t dec_mode;
    logic [16:0]    dec_const;
    logic [GW-1:0]  dec_ra, dec_rb;
    logic [15:0]    dec_ga, dec_gb, dec_bg;
    logic           dec_base_b;
    always_comb begin
        dec_mode   = pli_pkg::MODE_CONST;
        dec_const  = pli_pkg::ONE_Q16;
        dec_ra     = ir_reg;
        dec_rb     = ir_reg + GW'(1);
        dec_ga     = ia_reg;
        dec_gb     = ib_reg;
        dec_bg     = ia_reg;
        dec_base_b = 1'b0;
        if (!is_time_reg) begin
            if (int'(sp_reg) >= SPECIES) begin
                dec_mode = pli_pkg::MODE_CONST;
            end else if (m_reg <= g0_reg) begin
                dec_mode = pli_pkg::MODE_LINE;
                dec_ra   = '0;
                dec_rb   = GW'(1);
                dec_ga   = g0_reg;
                dec_gb   = g1_reg;
                dec_bg   = g0_reg;
            end else if (m_reg >= gn1_reg) begin
                dec_mode   = pli_pkg::MODE_LINE;
                dec_ra     = GW'(GRID_POINTS - 2);
                dec_rb     = GW'(GRID_POINTS - 1);
                dec_ga     = gn2_reg;
                dec_gb     = gn1_reg;
                dec_bg     = gn1_reg;
                dec_base_b = 1'b1;
            end else if (found_reg) begin
                dec_mode = pli_pkg::MODE_LINE;
            end
        end else begin
            if (tb_reg == 5'd0) begin
                dec_const = '0;
            end else if (int'(sp_reg) >= SPECIES) begin
                dec_const = pli_pkg::ONE_Q16;
            end else if (int'(tb_reg) >= TIME_BINS) begin
                dec_const = '0;
            end else if (found_reg) begin
                dec_mode = pli_pkg::MODE_LINE;
            end else if (m_reg >= gn1_reg) begin
                dec_mode = pli_pkg::MODE_READ;
                dec_ra   = GW'(GRID_POINTS - 1);
            end else if (m_reg <= g0_reg) begin
                dec_mode = pli_pkg::MODE_READ;
                dec_ra   = '0;
            end
        end
    end

    // multiply stage operands
    logic signed [16:0] diff_s, dm_s, den_s;
    assign diff_s = $signed({1'b0, mem_q}) - $signed({1'b0, va_reg});
    assign dm_s   = $signed({1'b0, m_reg}) - $signed({1'b0, bg_reg});
    assign den_s  = $signed({1'b0, gb_reg}) - $signed({1'b0, ga_reg});

    // divider step
    logic [16:0] trial;
    assign trial = {rem_reg, quo_reg[QW-1]} - {1'b0, dsor_reg};

    // final sum and saturation
    logic signed [34:0] q_s, sum_s;
    assign q_s   = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    assign sum_s = $signed({19'd0, basev_reg}) + q_s;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && ((in_kind == pli_pkg::KIND_Q_ELOSS)
                               || (in_kind == pli_pkg::KIND_Q_TIME))) begin
                    state_next = ST_BIN;
                end
            end
            ST_BIN:    state_next = ST_SCAN;
            ST_SCAN: begin
                if (int'(scan_cnt_reg) == GRID_POINTS) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = ST_RDA;
            ST_RDA:    state_next = ST_RDB;
            ST_RDB:    state_next = ST_MUL;
            ST_MUL: begin
                if (mode_reg == pli_pkg::MODE_LINE && den_s != 17'sd0) begin
                    state_next = ST_DIVI;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIVI:   state_next = ST_DIV;
            ST_DIV: begin
                if (int'(div_cnt_reg) == QW - 1) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:    state_next = ST_OUT;
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scale_reg    <= 24'd65536;
            bins_reg     <= 8'd128;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    pli_pkg::CFG_CHARGE_SCALE: scale_reg <= cfg_wdata;
                    pli_pkg::CFG_BINS_IN_USE:  bins_reg  <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // drop the result once taken; load a new one when the slot is free
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                is_time_reg  <= (in_kind == pli_pkg::KIND_Q_TIME);
                sp_reg       <= in_species;
                m_reg        <= in_momentum;
                charge_reg   <= in_charge;
                tb_reg       <= in_tbin;
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            ST_BIN: begin
                binprod_reg <= 40'(charge_reg) * 40'(scale_reg);
            end
            ST_SCAN: begin
                scan_cnt_reg <= scan_cnt_reg + CW'(1);
                if (scan_cnt_reg == '0) begin
                    bin_reg <= bin_capped;
                end else begin
                    // track end pairs and the first interval that holds m
                    if (scan_j == CW'(0))               g0_reg  <= grid_q_reg;
                    if (scan_j == CW'(1))               g1_reg  <= grid_q_reg;
                    if (int'(scan_j) == GRID_POINTS - 2) gn2_reg <= grid_q_reg;
                    if (int'(scan_j) == GRID_POINTS - 1) gn1_reg <= grid_q_reg;
                    if (scan_j != CW'(0) && !found_reg
                        && gprev_reg <= m_reg && m_reg < grid_q_reg) begin
                        found_reg <= 1'b1;
                        ia_reg    <= gprev_reg;
                        ib_reg    <= grid_q_reg;
                        ir_reg    <= GW'(scan_j - CW'(1));
                    end
                    gprev_reg <= grid_q_reg;
                end
            end
            ST_DECIDE: begin
                mode_reg   <= dec_mode;
                const_reg  <= dec_const;
                ra_reg     <= dec_ra;
                rb_reg     <= dec_rb;
                ga_reg     <= dec_ga;
                gb_reg     <= dec_gb;
                bg_reg     <= dec_bg;
                base_b_reg <= dec_base_b;
            end
            ST_RDB: begin
                va_reg <= mem_q;
            end
            ST_MUL: begin
                prod_reg  <= 34'(diff_s) * 34'(dm_s);
                den_reg   <= den_s;
                basev_reg <= base_b_reg ? mem_q : va_reg;
                unique case (mode_reg)
                    pli_pkg::MODE_CONST: res_reg <= const_reg;
                    pli_pkg::MODE_READ:  res_reg <= {1'b0, va_reg};
                    pli_pkg::MODE_LINE:  res_reg <= {1'b0, base_b_reg ? mem_q : va_reg};
                    default:             res_reg <= const_reg;
                endcase
                prob_reg <= '0;
                sat_reg  <= 1'b0;
            end
            ST_DIVI: begin
                quo_reg     <= prod_reg[33] ? QW'(-prod_reg) : QW'(prod_reg);
                dsor_reg    <= den_reg[16] ? 16'(-den_reg) : 16'(den_reg);
                neg_reg     <= prod_reg[33] ^ den_reg[16];
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV: begin
                div_cnt_reg <= div_cnt_reg + DCW'(1);
                if (!trial[16]) begin
                    rem_reg <= trial[15:0];
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[14:0], quo_reg[QW-1]};
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
            end
            ST_SUM: begin
                if (sum_s > 35'(pli_pkg::OUT_MAX)) begin
                    prob_reg <= pli_pkg::OUT_MAX;
                    sat_reg  <= 1'b1;
                end else if (sum_s < 35'(pli_pkg::OUT_MIN)) begin
                    prob_reg <= pli_pkg::OUT_MIN;
                    sat_reg  <= 1'b1;
                end else begin
                    prob_reg <= sum_s[pli_pkg::PROB_W-1:0];
                    sat_reg  <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // result register; prob_reg holds the divided path, res_reg the direct one
    logic from_div_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            from_div_reg <= (mode_reg == pli_pkg::MODE_LINE) && (den_s != 17'sd0);
        end
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= from_div_reg ? prob_reg : pli_pkg::PROB_W'(res_reg);
            m_tuser_reg <= from_div_reg ? sat_reg : 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: design/pli_checker.sv
`include "pid_likelihood_interpolator_defines.svh"

module pli_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [pli_pkg::PROB_W-1:0] m_tdata,
    input logic        m_tuser
);

    logic q_xfer, w_xfer;
    assign q_xfer = s_tvalid && s_tready && (s_tuser == pli_pkg::KIND_Q_ELOSS
                                             || s_tuser == pli_pkg::KIND_Q_TIME);
    assign w_xfer = s_tvalid && s_tready && (s_tuser == pli_pkg::KIND_WR_ELOSS
                                             || s_tuser == pli_pkg::KIND_WR_TIME
                                             || s_tuser == pli_pkg::KIND_WR_GRID);

    `PLI_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `PLI_ASSERT_NXT(a_query_busy, q_xfer, !s_tready, "query transfer left input ready")
    `PLI_ASSERT_NXT(a_write_quick, w_xfer, s_tready, "write transfer blocked input")
    `PLI_ASSERT_IMP(a_sat_rail, m_tvalid && m_tuser, m_tdata == pli_pkg::OUT_MAX || m_tdata == pli_pkg::OUT_MIN, "saturated flag off rail")

endmodule

bind pid_likelihood_interpolator pli_checker u_pli_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
